/* rtl/dil_pkg.sv */
`default_nettype none

package dil_pkg;

    // Default width of a valid result, and the fixed width of the value field
    localparam int VALUE_WIDTH_DEF = 64;
    localparam int VALUE_BITS      = 64;

    // Character codes
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_COMMENT = 2'd1,
        MODE_NUMBER  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_NOT_DELIMITED = 3'd1,
        ST_END           = 3'd2,
        ST_UNEXPECTED    = 3'd3,
        ST_OVERFLOW      = 3'd4
    } t_status;

    // Lexer control state, apart from the magnitude
    typedef struct packed {
        t_mode mode;
        logic  negative;
        logic  saturated;
    } t_ctl;

    // Result request from one step
    typedef struct packed {
        logic    valid;
        t_status status;
    } t_emit;

endpackage

`default_nettype wire

/* rtl/dil_in_if.sv */
`default_nettype none

interface dil_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_stream;

    modport source (output valid, output char_code, output end_of_stream, input ready);
    modport sink   (input valid, input char_code, input end_of_stream, output ready);
endinterface

`default_nettype wire

/* rtl/dil_out_if.sv */
`default_nettype none

interface dil_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [dil_pkg::VALUE_BITS-1:0] value;
    logic [2:0]                           status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

/* rtl/dil_step.sv */
`default_nettype none

module dil_step #(
    parameter int VALUE_WIDTH = dil_pkg::VALUE_WIDTH_DEF
) (
    input  wire  dil_pkg::t_ctl                   i_ctl,
    input  wire  logic [VALUE_WIDTH-1:0]          i_mag,
    input  wire  logic [7:0]                      i_char,
    input  wire  logic                            i_eos,
    output dil_pkg::t_ctl                         o_ctl,
    output logic [VALUE_WIDTH-1:0]                o_mag,
    output dil_pkg::t_emit                        o_emit,
    output logic signed [dil_pkg::VALUE_BITS-1:0] o_value
);

    localparam logic [VALUE_WIDTH-1:0] CAP = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic                     is_space;
    logic                     is_digit;
    logic                     is_delim;
    logic                     overflow;
    logic [VALUE_WIDTH+3:0]   prod;
    logic [VALUE_WIDTH-1:0]   signed_mag;

    // Classify the character
    always_comb begin
        is_space = (i_char == dil_pkg::CH_SPACE) ||
                   ((i_char >= dil_pkg::CH_TAB) && (i_char <= dil_pkg::CH_CR));
        is_digit = (i_char >= dil_pkg::CH_ZERO) && (i_char <= dil_pkg::CH_NINE);
        is_delim = is_space || (i_char == dil_pkg::CH_LPAREN) ||
                   (i_char == dil_pkg::CH_RPAREN) || (i_char == dil_pkg::CH_QUOTE) ||
                   (i_char == dil_pkg::CH_SEMI);
    end

    // Magnitude times ten plus digit; it exceeds the cap exactly when saturation is due
    assign prod = ({4'b0000, i_mag} << 3) + ({4'b0000, i_mag} << 1) +
                  (VALUE_WIDTH+4)'(i_char[3:0]);

    // Finished number: overflow check and two's complement value
    assign overflow   = i_ctl.saturated || (!i_ctl.negative && i_mag[VALUE_WIDTH-1]);
    assign signed_mag = i_ctl.negative ? (VALUE_WIDTH)'(0) - i_mag : i_mag;

    // Next state and result
    always_comb begin
        o_ctl          = i_ctl;
        o_mag          = i_mag;
        o_emit.valid   = 1'b0;
        o_emit.status  = dil_pkg::ST_OK;
        o_value        = '0;
        case (i_ctl.mode)
            dil_pkg::MODE_COMMENT: begin
                if (i_eos) begin
                    o_ctl.mode    = dil_pkg::MODE_IDLE;
                    o_emit.valid  = 1'b1;
                    o_emit.status = dil_pkg::ST_END;
                end else if ((i_char == dil_pkg::CH_CR) || (i_char == dil_pkg::CH_LF)) begin
                    o_ctl.mode = dil_pkg::MODE_IDLE;
                end
            end
            dil_pkg::MODE_NUMBER: begin
                if (!i_eos && is_digit) begin
                    if (!i_ctl.saturated) begin
                        if (prod > {4'b0000, CAP}) begin
                            o_mag           = CAP;
                            o_ctl.saturated = 1'b1;
                        end else begin
                            o_mag = prod[VALUE_WIDTH-1:0];
                        end
                    end
                end else if (i_eos || is_delim) begin
                    // delimiter or end closes the number
                    o_emit.valid    = 1'b1;
                    o_emit.status   = overflow ? dil_pkg::ST_OVERFLOW : dil_pkg::ST_OK;
                    o_value         = overflow ? '0
                                      : dil_pkg::VALUE_BITS'(signed'(signed_mag));
                    o_ctl.negative  = 1'b0;
                    o_ctl.saturated = 1'b0;
                    o_mag           = '0;
                    o_ctl.mode      = (!i_eos && (i_char == dil_pkg::CH_SEMI))
                                      ? dil_pkg::MODE_COMMENT : dil_pkg::MODE_IDLE;
                end else begin
                    // drop the number on a stray character
                    o_emit.valid    = 1'b1;
                    o_emit.status   = dil_pkg::ST_NOT_DELIMITED;
                    o_ctl.negative  = 1'b0;
                    o_ctl.saturated = 1'b0;
                    o_mag           = '0;
                    o_ctl.mode      = dil_pkg::MODE_IDLE;
                end
            end
            default: begin
                o_ctl.mode = dil_pkg::MODE_IDLE;
                if (i_eos) begin
                    o_emit.valid  = 1'b1;
                    o_emit.status = dil_pkg::ST_END;
                end else if (is_space) begin
                    o_ctl.mode = dil_pkg::MODE_IDLE;
                end else if (i_char == dil_pkg::CH_SEMI) begin
                    o_ctl.mode = dil_pkg::MODE_COMMENT;
                end else if ((i_char == dil_pkg::CH_LPAREN) || (i_char == dil_pkg::CH_RPAREN) ||
                             (i_char == dil_pkg::CH_QUOTE)) begin
                    o_emit.valid  = 1'b1;
                    o_emit.status = dil_pkg::ST_UNEXPECTED;
                end else begin
                    o_ctl.negative  = 1'b0;
                    o_ctl.saturated = 1'b0;
                    o_mag           = '0;
                    if ((i_char == dil_pkg::CH_MINUS) || (i_char == dil_pkg::CH_PLUS)) begin
                        o_ctl.negative = (i_char == dil_pkg::CH_MINUS);
                        o_ctl.mode     = dil_pkg::MODE_NUMBER;
                    end else if (is_digit) begin
                        o_mag      = (VALUE_WIDTH)'(i_char[3:0]);
                        o_ctl.mode = dil_pkg::MODE_NUMBER;
                    end else begin
                        o_emit.valid  = 1'b1;
                        o_emit.status = dil_pkg::ST_NOT_DELIMITED;
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/decimal_integer_lexer.sv */
// A taken word is held in the input register, then its result in the result register.
// Throughput: one character word per cycle while o_out.ready does not stall the result,
// set by the single lexer step between the two registers (compare, times ten and add).
// Reset: synchronous active low; clears mode, sign, magnitude, saturation and
// both valid flags. No clearing pass is needed.
`default_nettype none

module decimal_integer_lexer #(
    parameter int VALUE_WIDTH = dil_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dil_in_if.sink     i_in,
    dil_out_if.source  o_out
);

    logic                                 r_in_valid;
    logic [7:0]                           r_char;
    logic                                 r_eos;

    dil_pkg::t_ctl                        r_ctl;
    dil_pkg::t_ctl                        n_ctl;
    logic [VALUE_WIDTH-1:0]               r_mag;
    logic [VALUE_WIDTH-1:0]               n_mag;

    dil_pkg::t_emit                       step_emit;
    logic signed [dil_pkg::VALUE_BITS-1:0] step_value;

    logic                                 r_out_valid;
    logic signed [dil_pkg::VALUE_BITS-1:0] r_value;
    dil_pkg::t_status                     r_status;

    logic                                 proc;

    // Advance the held word when the result register is free or being emptied
    assign proc       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || proc;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_char <= i_in.char_code;
            r_eos  <= i_in.end_of_stream;
        end
    end

    dil_step #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_step (
        .i_ctl   (r_ctl),
        .i_mag   (r_mag),
        .i_char  (r_char),
        .i_eos   (r_eos),
        .o_ctl   (n_ctl),
        .o_mag   (n_mag),
        .o_emit  (step_emit),
        .o_value (step_value)
    );

    // Lexer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.mode      <= dil_pkg::MODE_IDLE;
            r_ctl.negative  <= 1'b0;
            r_ctl.saturated <= 1'b0;
            r_mag           <= '0;
        end else if (proc) begin
            r_ctl <= n_ctl;
            r_mag <= n_mag;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= step_emit.valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && step_emit.valid) begin
            r_value  <= step_value;
            r_status <= step_emit.status;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.value  = r_value;
    assign o_out.status = r_status;

`ifndef SYNTHESIS
    // Error results carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status != dil_pkg::ST_OK) |-> (r_value == '0))
        else $error("error result with non-zero value");

    // Saturation only inside a number, with the magnitude pinned at the cap
    a_sat_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.saturated |-> (r_ctl.mode == dil_pkg::MODE_NUMBER) &&
                            (r_mag == {1'b1, {(VALUE_WIDTH-1){1'b0}}}))
        else $error("saturation outside a number or below the cap");

    // A stalled result holds while a new word waits behind it
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_value) && $stable(r_status))
        else $error("stalled result changed");

    // The state moves only when a held word is processed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !proc |=> $stable(r_ctl) && $stable(r_mag))
        else $error("lexer state changed without a word");
`endif

endmodule

`default_nettype wire
